// File: sv/gpe_euler_stencil_step_assert.svh
// assertion macros for the stencil step block
`ifndef GPE_EULER_STENCIL_STEP_ASSERT_SVH
`define GPE_EULER_STENCIL_STEP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GPE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define GPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/gpe_pkg.sv
`timescale 1ns / 1ps
package gpe_pkg;

  localparam int PSI_BITS = 16;
  localparam int POT_BITS = 24;

  localparam logic signed [PSI_BITS-1:0] PSI_MAX = {1'b0, {(PSI_BITS-1){1'b1}}};
  localparam logic signed [PSI_BITS-1:0] PSI_MIN = {1'b1, {(PSI_BITS-1){1'b0}}};

  // configuration register indexes
  localparam logic [2:0] CFG_ROW_COUNT    = 3'd0;
  localparam logic [2:0] CFG_COL_COUNT    = 3'd1;
  localparam logic [2:0] CFG_NONLIN_COEFF = 3'd2;
  localparam logic [2:0] CFG_TIME_STEP    = 3'd3;
  localparam logic [2:0] CFG_INV_DX_SQ    = 3'd4;
  localparam logic [2:0] CFG_INV_DY_SQ    = 3'd5;

  typedef logic signed [PSI_BITS-1:0] psi_t;
  typedef logic signed [POT_BITS-1:0] pot_t;

  typedef struct packed {
    logic req_type;
    psi_t psi_re;
    psi_t psi_im;
    pot_t potential;
  } in_item_t;

  typedef struct packed {
    psi_t new_re;
    psi_t new_im;
    logic frame_last;
  } out_item_t;

  // one line-buffer entry: rows r-2 and r-1 plus potential of row r-1
  typedef struct packed {
    psi_t older_re;
    psi_t older_im;
    psi_t center_re;
    psi_t center_im;
    pot_t pot;
  } line_ent_t;

  // stencil operands handed to the arithmetic pipeline
  typedef struct packed {
    psi_t c_re;
    psi_t c_im;
    psi_t up_re;
    psi_t up_im;
    psi_t dn_re;
    psi_t dn_im;
    psi_t lf_re;
    psi_t lf_im;
    psi_t rt_re;
    psi_t rt_im;
    pot_t pot;
  } calc_op_t;

  typedef struct packed {
    logic signed [23:0] g;
    logic [23:0]        dt;
    logic [23:0]        idx;
    logic [23:0]        idy;
  } calc_cfg_t;

  typedef struct packed {
    psi_t re;
    psi_t im;
  } calc_res_t;

endpackage

// File: sv/gpe_point_calc.sv
`timescale 1ns / 1ps
module gpe_point_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  gpe_pkg::calc_op_t  op,
  input  gpe_pkg::calc_cfg_t cf,
  output logic               done,
  output gpe_pkg::calc_res_t res
);

  localparam int STAGES = 8;

  logic [STAGES-1:0] vld_r;

  gpe_pkg::psi_t c_k [2];
  gpe_pkg::psi_t up_k [2];
  gpe_pkg::psi_t dn_k [2];
  gpe_pkg::psi_t lf_k [2];
  gpe_pkg::psi_t rt_k [2];

  logic signed [31:0] a_sqre_r, a_sqim_r;
  logic signed [17:0] a_dx_r [2];
  logic signed [17:0] a_dy_r [2];
  logic [20:0]        b_m_r;
  logic signed [42:0] b_lx_r [2];
  logic signed [42:0] b_ly_r [2];
  logic signed [45:0] c_gm_r;
  logic signed [43:0] c_lap_r [2];
  logic signed [29:0] d_w_r;
  logic signed [45:0] e_wc_r [2];
  logic signed [39:0] f_t_r [2];
  logic [41:0]        g_lo_r [2];
  logic signed [46:0] g_hi_r [2];
  gpe_pkg::psi_t      h_res_r [2];

  logic signed [46:0] f_rnd4 [2];
  logic signed [47:0] f_d [2];
  logic signed [48:0] f_q [2];
  logic signed [63:0] h_sum [2];
  logic signed [63:0] h_rnd [2];
  logic signed [40:0] h_val [2];
  gpe_pkg::psi_t      h_sat [2];

  assign c_k[0]  = op.c_re;
  assign c_k[1]  = op.c_im;
  assign up_k[0] = op.up_re;
  assign up_k[1] = op.up_im;
  assign dn_k[0] = op.dn_re;
  assign dn_k[1] = op.dn_im;
  assign lf_k[0] = op.lf_re;
  assign lf_k[1] = op.lf_im;
  assign rt_k[0] = op.rt_re;
  assign rt_k[1] = op.rt_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], start};
    end
  end

  assign done = vld_r[STAGES-1];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      f_rnd4[k] = (47'(e_wc_r[k]) + 47'sd8) >>> 4;
      f_d[k]    = 48'(c_lap_r[k]) - 48'(f_rnd4[k]);
      f_q[k]    = (49'(f_d[k]) + 49'sd128) >>> 8;
      h_sum[k]  = (64'(g_hi_r[k]) <<< 18) + $signed({22'd0, g_lo_r[k]});
      h_rnd[k]  = (h_sum[k] + 64'sd8388608) >>> 24;
      h_val[k]  = 41'(c_k[k]) + 41'(h_rnd[k]);
      if (h_val[k] > 41'(gpe_pkg::PSI_MAX)) begin
        h_sat[k] = gpe_pkg::PSI_MAX;
      end else if (h_val[k] < 41'(gpe_pkg::PSI_MIN)) begin
        h_sat[k] = gpe_pkg::PSI_MIN;
      end else begin
        h_sat[k] = gpe_pkg::PSI_BITS'(h_val[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    // squares and second differences
    a_sqre_r <= c_k[0] * c_k[0];
    a_sqim_r <= c_k[1] * c_k[1];
    for (int k = 0; k < 2; k++) begin
      a_dx_r[k] <= 18'(up_k[k]) + 18'(dn_k[k]) - (18'(c_k[k]) <<< 1);
      a_dy_r[k] <= 18'(lf_k[k]) + 18'(rt_k[k]) - (18'(c_k[k]) <<< 1);
    end
    // |psi|^2 to Q.16, laplacian terms
    b_m_r <= 21'((33'($unsigned(a_sqre_r)) + 33'($unsigned(a_sqim_r)) + 33'd2048) >> 12);
    for (int k = 0; k < 2; k++) begin
      b_lx_r[k] <= a_dx_r[k] * $signed({1'b0, cf.idx});
      b_ly_r[k] <= a_dy_r[k] * $signed({1'b0, cf.idy});
    end
    c_gm_r <= cf.g * $signed({1'b0, b_m_r});
    for (int k = 0; k < 2; k++) begin
      c_lap_r[k] <= 44'(b_lx_r[k]) + 44'(b_ly_r[k]);
    end
    d_w_r <= 30'(op.pot) + 30'((47'(c_gm_r) + 47'sd32768) >>> 16);
    for (int k = 0; k < 2; k++) begin
      e_wc_r[k] <= d_w_r * c_k[k];
    end
    // multiplying by i swaps the parts and negates the new real
    f_t_r[0] <= -40'(f_q[1]);
    f_t_r[1] <= 40'(f_q[0]);
    // dt product split into two partial products
    for (int k = 0; k < 2; k++) begin
      g_lo_r[k] <= cf.dt * f_t_r[k][17:0];
      g_hi_r[k] <= $signed({1'b0, cf.dt}) * $signed(f_t_r[k][39:18]);
      h_res_r[k] <= h_sat[k];
    end
  end

  assign res.re = h_res_r[0];
  assign res.im = h_res_r[1];

endmodule

// File: sv/gpe_euler_stencil_step.sv
`timescale 1ns / 1ps
// Forward Euler step of a 2-D complex wave function over a raster-order frame
// with a five-point stencil. Each grid point beat updates the point one row
// above it; row 0 only fills the line buffer, and after the last row a run of
// drain beats (one per column) flushes the last row, the final one carrying
// frame_last. Beats that do not fit the frame position (a grid point after
// the last row, a drain beat too early) are dropped. An item that is used
// passes from accept to the next possible accept through a read of column
// c and c+1 from the line memory's one read port, the 8-stage arithmetic
// pipeline, then a write-back state; one item is in work at a time. The
// result sits in an output register, so a stalled result only holds the
// block in its write-back cycle. Line memory contents come out of reset as
// zero through per-column valid bits; no clearing pass is needed.
// Configuration is written through cfg_*, which is always ready.
module gpe_euler_stencil_step #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gpe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gpe_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int CW1 = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDC  = 3'd1;
  localparam logic [2:0] ST_RDR  = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // configuration registers
  logic [10:0]        row_count_r;
  logic [8:0]         col_count_r;
  logic signed [23:0] nonlin_coeff_r;
  logic [23:0]        time_step_r;
  logic [23:0]        inv_dx_sq_r;
  logic [23:0]        inv_dy_sq_r;

  // frame position and control
  logic [2:0]         state_r;
  logic [RW-1:0]      row_idx_r;
  logic [CW-1:0]      col_idx_r;
  logic [MAX_COLS-1:0] ent_vld_r;
  logic               drain_r, last_r, up_r, emit_r, start_r;
  gpe_pkg::in_item_t  item_r;
  gpe_pkg::psi_t      left_re_r, left_im_r;
  gpe_pkg::calc_op_t  op_r;

  // line memory
  gpe_pkg::line_ent_t line_mem [MAX_COLS];
  gpe_pkg::line_ent_t rd_q_r;
  logic               rd_v_r;
  logic [CW-1:0]      rd_addr;
  logic               mem_we;
  gpe_pkg::line_ent_t mem_wd;

  logic               out_valid_r;
  gpe_pkg::out_item_t out_data_r;

  logic [RW-1:0]      rows;
  logic [CW1-1:0]     cols;
  logic               draining, last_col, accept, take, fin_go;
  gpe_pkg::psi_t      cen_re, cen_im;
  gpe_pkg::calc_cfg_t calc_cf;
  gpe_pkg::calc_res_t calc_res;
  logic               calc_done;

  // frame size clamped to 1..MAX_ROWS rows and to the 1..MAX_COLS columns the line buffer holds
  always_comb begin
    if (row_count_r == 11'd0) begin
      rows = RW'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(row_count_r);
    end
    if (col_count_r == 9'd0) begin
      cols = CW1'(1);
    end else if (32'(col_count_r) > MAX_COLS) begin
      cols = CW1'(MAX_COLS);
    end else begin
      cols = CW1'(col_count_r);
    end
  end

  assign draining = 32'(row_idx_r) >= 32'(rows);
  assign last_col = (32'(col_idx_r) + 32'd1) >= 32'(cols);

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // a beat is used only when its kind matches the frame position
  assign take     = accept && (in_data.req_type == draining);
  assign fin_go   = (state_r == ST_FIN) && (!emit_r || !out_valid_r || !out_stall);

  assign cfg_ready = 1'b1;

  // never-written entries read as zero
  assign cen_re = rd_v_r ? rd_q_r.center_re : '0;
  assign cen_im = rd_v_r ? rd_q_r.center_im : '0;

  // second read of a point fetches the right-hand neighbour
  assign rd_addr = (state_r == ST_RDC) ? col_idx_r + CW'(1) : col_idx_r;

  assign mem_we           = fin_go && !drain_r;
  assign mem_wd.older_re  = op_r.c_re;
  assign mem_wd.older_im  = op_r.c_im;
  assign mem_wd.center_re = item_r.psi_re;
  assign mem_wd.center_im = item_r.psi_im;
  assign mem_wd.pot       = item_r.potential;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[col_idx_r] <= mem_wd;
    end
    rd_q_r <= line_mem[rd_addr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= 11'd64;
      col_count_r    <= 9'd64;
      nonlin_coeff_r <= '0;
      time_step_r    <= 24'd4096;
      inv_dx_sq_r    <= 24'd256;
      inv_dy_sq_r    <= 24'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gpe_pkg::CFG_ROW_COUNT:    row_count_r    <= cfg_data[10:0];
        gpe_pkg::CFG_COL_COUNT:    col_count_r    <= cfg_data[8:0];
        gpe_pkg::CFG_NONLIN_COEFF: nonlin_coeff_r <= $signed(cfg_data);
        gpe_pkg::CFG_TIME_STEP:    time_step_r    <= cfg_data;
        gpe_pkg::CFG_INV_DX_SQ:    inv_dx_sq_r    <= cfg_data;
        gpe_pkg::CFG_INV_DY_SQ:    inv_dy_sq_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: read c, read c+1, compute, write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_idx_r   <= '0;
      col_idx_r   <= '0;
      ent_vld_r   <= '0;
      rd_v_r      <= 1'b0;
      start_r     <= 1'b0;
      left_re_r   <= '0;
      left_im_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r  <= ent_vld_r[rd_addr];
      start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (take) begin
            state_r <= ST_RDC;
          end
        end
        ST_RDC: begin
          state_r <= ST_RDR;
        end
        ST_RDR: begin
          start_r <= 1'b1;
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          if (calc_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            if (emit_r) begin
              out_valid_r <= 1'b1;
            end
            if (!drain_r) begin
              ent_vld_r[col_idx_r] <= 1'b1;
            end
            left_re_r <= op_r.c_re;
            left_im_r <= op_r.c_im;
            if (last_r) begin
              col_idx_r <= '0;
              row_idx_r <= drain_r ? '0 : row_idx_r + RW'(1);
            end else begin
              col_idx_r <= col_idx_r + CW'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // item payload and stencil operands
  always_ff @(posedge clk) begin
    if (take) begin
      item_r  <= in_data;
      drain_r <= in_data.req_type;
      last_r  <= last_col;
      up_r    <= (32'(row_idx_r) >= 32'd2);
      emit_r  <= (row_idx_r != '0);
    end
    if (state_r == ST_RDC) begin
      op_r.c_re  <= cen_re;
      op_r.c_im  <= cen_im;
      op_r.up_re <= (up_r && rd_v_r) ? rd_q_r.older_re : '0;
      op_r.up_im <= (up_r && rd_v_r) ? rd_q_r.older_im : '0;
      op_r.dn_re <= drain_r ? '0 : item_r.psi_re;
      op_r.dn_im <= drain_r ? '0 : item_r.psi_im;
      op_r.lf_re <= (col_idx_r == '0) ? '0 : left_re_r;
      op_r.lf_im <= (col_idx_r == '0) ? '0 : left_im_r;
      op_r.pot   <= rd_v_r ? rd_q_r.pot : '0;
    end
    if (state_r == ST_RDR) begin
      op_r.rt_re <= last_r ? '0 : cen_re;
      op_r.rt_im <= last_r ? '0 : cen_im;
    end
    if (fin_go && emit_r) begin
      out_data_r.new_re     <= calc_res.re;
      out_data_r.new_im     <= calc_res.im;
      out_data_r.frame_last <= drain_r && last_r;
    end
  end

  assign calc_cf.g   = nonlin_coeff_r;
  assign calc_cf.dt  = time_step_r;
  assign calc_cf.idx = inv_dx_sq_r;
  assign calc_cf.idy = inv_dy_sq_r;

  gpe_point_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .op    (op_r),
    .cf    (calc_cf),
    .done  (calc_done),
    .res   (calc_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/gpe_checker.sv
`timescale 1ns / 1ps
`include "gpe_euler_stencil_step_assert.svh"
module gpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input gpe_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input gpe_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [23:0]        cfg_data
);

  // a stalled result beat holds
  `GPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // a result never shows up the cycle after an input beat is taken
  `GPE_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid))

  // a new result is loaded only as the block returns to accepting input
  `GPE_ASSERT_IMPL(a_result_idle, $rose(out_valid), !in_stall)

  // configuration writes are never held off
  `GPE_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind gpe_euler_stencil_step gpe_checker u_gpe_checker (.*);
